>>> sv/ifsc_pkg.sv
// shared types and constants for the ipv4 frame source check block
// no dependencies; imported by ifsc_frame_check and the top level
`timescale 1ns / 1ps

package ifsc_pkg;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned HDR_W   = 6;
  localparam int unsigned SUM_W   = 21;

  // byte positions in the captured frame
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;
  localparam logic [COUNT_W-1:0] POS_MAC_FIRST  = 7'd6;
  localparam logic [COUNT_W-1:0] POS_MAC_LAST   = 7'd11;
  localparam logic [COUNT_W-1:0] POS_TYPE_HI    = 7'd12;
  localparam logic [COUNT_W-1:0] POS_TYPE_LO    = 7'd13;
  localparam logic [COUNT_W-1:0] ETH_HDR        = 7'd14;
  localparam logic [COUNT_W-1:0] POS_TOTAL_HI   = 7'd16;
  localparam logic [COUNT_W-1:0] POS_TOTAL_LO   = 7'd17;
  localparam logic [COUNT_W-1:0] IP_SRC_POS     = 7'd26;
  localparam logic [COUNT_W-1:0] IP_SRC_LAST    = 7'd29;
  localparam logic [COUNT_W-1:0] MIN_CAPTURE    = 7'd34;

  localparam logic [HDR_W-1:0] MIN_IHL_BYTES    = 6'd20;
  localparam logic [7:0]       ETYPE_HI_IPV4    = 8'h08;
  localparam logic [7:0]       ETYPE_LO_IPV4    = 8'h00;
  localparam logic [3:0]       IP_VERSION_4     = 4'd4;
  localparam logic [15:0]      SUM_GOOD         = 16'hFFFF;
  localparam int unsigned      MAC_GROUP_BIT    = 40;

  typedef struct packed {
    logic        accepted;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
  } verdict_t;

endpackage

>>> sv/ipv4_frame_source_check_top.sv
// top level: input word register, frame checker, result register
// depends on ifsc_pkg and ifsc_frame_check
`timescale 1ns / 1ps
// a last word's result is loaded into the result register once the word leaves the input word register
// throughput: one word per cycle; only a last word waiting on an untaken
//   result holds off the input, set by the single result register
// reset: synchronous rst clears the pipeline valids and all frame state

module ipv4_frame_source_check_top import ifsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic [15:0] frame_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [47:0] source_mac,
  output logic [31:0] source_ip
);

  // input word register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic [15:0] s1_length;

  logic        stall;
  logic        s1_step;
  verdict_t    verdict;

  // a last word can only move when the result register is free or emptying
  assign stall    = s1_valid && s1_last && out_valid && !out_ready;
  assign s1_step  = s1_valid && !stall;
  assign in_ready = !s1_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte   <= frame_byte;
      s1_last   <= last_byte;
      s1_length <= frame_length;
    end
  end

  // per-frame parse state and verdict
  ifsc_frame_check u_check (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_step),
    .frame_byte   (s1_byte),
    .last_byte    (s1_last),
    .frame_length (s1_length),
    .verdict      (verdict)
  );

  // result register, loaded by a last word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_last) begin
      accepted   <= verdict.accepted;
      source_mac <= verdict.source_mac;
      source_ip  <= verdict.source_ip;
    end
  end

  // rejected frames carry zero addresses
  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (source_mac == 48'd0 && source_ip == 32'd0))
    else $error("rejected result carries nonzero address");

  // accepted source mac is unicast and nonzero
  a_accept_mac : assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (!source_mac[MAC_GROUP_BIT] && source_mac != 48'd0))
    else $error("accepted result with bad source mac");

  // input held off only by a waiting last word
  a_ready_cause : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_last && out_valid && !out_ready))
    else $error("input stalled without cause");

  // a last word that moves always yields a result
  a_last_result : assert property (@(posedge clk) disable iff (rst)
    (s1_step && s1_last) |=> out_valid)
    else $error("last word produced no result");

endmodule

>>> sv/ifsc_frame_check.sv
// per-frame parse state and the end-of-frame verdict logic
// depends on ifsc_pkg
`timescale 1ns / 1ps

module ifsc_frame_check import ifsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic [15:0] frame_length,
  output verdict_t    verdict
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [HDR_W-1:0]   header_bytes, header_bytes_next;
  logic [15:0]        total_length, total_length_next;
  logic [SUM_W-1:0]   sum_accumulator, sum_accumulator_next;
  logic [7:0]         pending_high_byte, pending_high_byte_next;
  logic [47:0]        mac_capture, mac_capture_next;
  logic [31:0]        ip_capture, ip_capture_next;
  logic               header_bad, header_bad_next;

  logic               take;
  logic               in_header;
  logic [16:0]        fold1;
  logic [16:0]        fold2;
  logic               ok;

  always_comb begin
    byte_count_next        = byte_count;
    header_bytes_next      = header_bytes;
    total_length_next      = total_length;
    sum_accumulator_next   = sum_accumulator;
    pending_high_byte_next = pending_high_byte;
    mac_capture_next       = mac_capture;
    ip_capture_next        = ip_capture;
    header_bad_next        = header_bad;

    take      = (byte_count != COUNT_MAX);
    in_header = (byte_count == ETH_HDR) ||
                ((byte_count > ETH_HDR) &&
                 ({1'b0, byte_count} < ({1'b0, ETH_HDR} + {2'b00, header_bytes})));

    if (take) begin
      byte_count_next = byte_count + 7'd1;
      if (byte_count >= POS_MAC_FIRST && byte_count <= POS_MAC_LAST) begin
        mac_capture_next = {mac_capture[39:0], frame_byte};
      end
      if (byte_count >= IP_SRC_POS && byte_count <= IP_SRC_LAST) begin
        ip_capture_next = {ip_capture[23:0], frame_byte};
      end
      if (byte_count == POS_TYPE_HI && frame_byte != ETYPE_HI_IPV4) begin
        header_bad_next = 1'b1;
      end
      if (byte_count == POS_TYPE_LO && frame_byte != ETYPE_LO_IPV4) begin
        header_bad_next = 1'b1;
      end
      if (byte_count == ETH_HDR) begin
        if (frame_byte[7:4] != IP_VERSION_4) begin
          header_bad_next = 1'b1;
        end
        header_bytes_next = {frame_byte[3:0], 2'b00};
      end
      if (byte_count == POS_TOTAL_HI) begin
        total_length_next = {frame_byte, 8'h00};
      end
      if (byte_count == POS_TOTAL_LO) begin
        total_length_next = {total_length[15:8], frame_byte};
      end
      // header starts on an even position, so bit 0 picks high or low byte
      if (in_header) begin
        if (!byte_count[0]) begin
          pending_high_byte_next = frame_byte;
        end else begin
          sum_accumulator_next = sum_accumulator +
                                 {5'd0, pending_high_byte, frame_byte};
        end
      end
    end
  end

  // ones' complement fold of the running sum
  assign fold1 = {1'b0, sum_accumulator_next[15:0]} + {12'd0, sum_accumulator_next[20:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

  assign ok = (byte_count_next >= MIN_CAPTURE) && !header_bad_next &&
              (header_bytes_next >= MIN_IHL_BYTES) &&
              ({1'b0, byte_count_next} >= ({1'b0, ETH_HDR} + {2'b00, header_bytes_next})) &&
              (total_length_next >= {10'd0, header_bytes_next}) &&
              ({1'b0, frame_length} >= ({10'd0, ETH_HDR} + {1'b0, total_length_next})) &&
              !mac_capture_next[MAC_GROUP_BIT] && (mac_capture_next != 48'd0) &&
              (fold2 == {1'b0, SUM_GOOD});

  assign verdict.accepted   = ok;
  assign verdict.source_mac = ok ? mac_capture_next : 48'd0;
  assign verdict.source_ip  = ok ? ip_capture_next : 32'd0;

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count        <= '0;
      header_bytes      <= '0;
      total_length      <= '0;
      sum_accumulator   <= '0;
      pending_high_byte <= '0;
      mac_capture       <= '0;
      ip_capture        <= '0;
      header_bad        <= 1'b0;
    end else if (step) begin
      byte_count        <= byte_count_next;
      header_bytes      <= header_bytes_next;
      total_length      <= total_length_next;
      sum_accumulator   <= sum_accumulator_next;
      pending_high_byte <= pending_high_byte_next;
      mac_capture       <= mac_capture_next;
      ip_capture        <= ip_capture_next;
      header_bad        <= header_bad_next;
    end
  end

endmodule
